// ===== hw/rtl/smec_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smec_pkg: shared definitions for the stack machine execute core
// Sizes, opcodes, error codes and the controller/datapath command and status.
// ----------------------------------------------------------------------------
package smec_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int HEAP_DEPTH  = 1024;
    localparam int CALL_DEPTH  = 64;
    localparam int LABEL_COUNT = 64;
    localparam int PC_WIDTH    = 16;

    localparam int DATA_W = 32;
    localparam int CMD_W  = 5;
    localparam int ERR_W  = 4;

    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int SCW = $clog2(STACK_DEPTH + 1);
    localparam int HAW = $clog2(HEAP_DEPTH);
    localparam int RAW = $clog2(CALL_DEPTH);
    localparam int RCW = $clog2(CALL_DEPTH + 1);
    localparam int LAW = $clog2(LABEL_COUNT);
    localparam int LCW = $clog2(LABEL_COUNT + 1);

    typedef enum logic [CMD_W-1:0] {
        OP_PUSH     = 5'd0,
        OP_DUP      = 5'd1,
        OP_COPY     = 5'd2,
        OP_SWAP     = 5'd3,
        OP_DISCARD  = 5'd4,
        OP_SLIDE    = 5'd5,
        OP_ADD      = 5'd6,
        OP_SUB      = 5'd7,
        OP_MUL      = 5'd8,
        OP_DIV      = 5'd9,
        OP_MOD      = 5'd10,
        OP_STORE    = 5'd11,
        OP_RETRIEVE = 5'd12,
        OP_MARK     = 5'd13,
        OP_CALL     = 5'd14,
        OP_JUMP     = 5'd15,
        OP_JZ       = 5'd16,
        OP_JNEG     = 5'd17,
        OP_RET      = 5'd18,
        OP_END      = 5'd19,
        OP_WRITEC   = 5'd20,
        OP_WRITEN   = 5'd21,
        OP_READC    = 5'd22,
        OP_READN    = 5'd23
    } opcode_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE        = 4'd0,
        ERR_STACK_EMPTY = 4'd1,
        ERR_STACK_FULL  = 4'd2,
        ERR_HEAP_ADDR   = 4'd3,
        ERR_NO_LABEL    = 4'd4,
        ERR_RET_EMPTY   = 4'd5,
        ERR_RET_FULL    = 4'd6,
        ERR_LABEL_FULL  = 4'd7,
        ERR_DIV_ZERO    = 4'd8,
        ERR_BAD_OP      = 4'd9,
        ERR_RANGE       = 4'd10
    } err_t;

    typedef enum logic [1:0] {DS_R_TOP, DS_R_SECOND, DS_R_COPY} ds_rsel_t;
    typedef enum logic [1:0] {DS_W_PUSH, DS_W_TOP, DS_W_SECOND, DS_W_SLIDE} ds_wsel_t;
    typedef enum logic [2:0] {WD_ARG, WD_A, WD_B, WD_R, WD_HEAP} ds_wdsel_t;
    typedef enum logic [1:0] {HW_STORE, HW_READ, HW_CLEAR} heap_wsel_t;
    typedef enum logic [2:0] {CNT_HOLD, CNT_INC, CNT_DEC, CNT_DEC2, CNT_SLIDE} cnt_op_t;
    typedef enum logic [1:0] {RC_HOLD, RC_INC, RC_DEC} rc_op_t;
    typedef enum logic [1:0] {NPC_PC, NPC_LABEL, NPC_RET} npc_sel_t;
    typedef enum logic [2:0] {ALU_ADD, ALU_SUB, ALU_MUL, ALU_DIV, ALU_MOD} alu_op_t;

    typedef struct packed {
        logic       latch;
        logic       ds_re;
        ds_rsel_t   ds_rsel;
        logic       ds_we;
        ds_wsel_t   ds_wsel;
        ds_wdsel_t  ds_wdsel;
        logic       cap_a;
        logic       cap_b;
        logic       cap_r;
        alu_op_t    alu_op;
        logic       div_start;
        logic       heap_re;
        logic       heap_we;
        heap_wsel_t heap_wsel;
        logic       heap_char;
        logic       clr_step;
        logic       rs_re;
        logic       rs_we;
        logic       lbl_start;
        logic       lbl_run;
        logic       lbl_we;
        cnt_op_t    cnt_op;
        rc_op_t     rc_op;
        logic       halt_set;
        logic       res_load;
        npc_sel_t   res_npc;
        logic       res_ov;
        logic       res_onum;
        err_t       res_err;
    } dp_cmd_t;

    typedef struct packed {
        logic n_zero;
        logic n_lt2;
        logic n_full;
        logic arg_bad;
        logic rc_zero;
        logic rc_full;
        logic lbl_full;
        logic lbl_hit;
        logic lbl_miss;
        logic a_zero;
        logic a_neg;
        logic a_heap_ok;
        logic b_heap_ok;
        logic div_done;
        logic clr_last;
        logic halt;
    } dp_stat_t;

    function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? (DATA_W'(0) - v) : v;
    endfunction

endpackage

// ===== hw/rtl/smec_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smec_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module smec_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/smec_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smec_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, pulses done at the end.
// ----------------------------------------------------------------------------
module smec_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [smec_pkg::DATA_W-1:0] dividend,
    input  logic [smec_pkg::DATA_W-1:0] divisor,
    output logic                       done,
    output logic [smec_pkg::DATA_W-1:0] quo,
    output logic [smec_pkg::DATA_W-1:0] rem
);

    localparam int W  = smec_pkg::DATA_W;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  dvs_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          done_reg, done_next;
    logic [W:0]    rem_sh;
    logic [W+1:0]  diff;

    assign rem_sh = {rem_reg, quo_reg[W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, dvs_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next = dividend;
            rem_next = '0;
            cnt_next = CW'(W);
        end else if (cnt_reg != '0) begin
            // subtract when it fits, shift in the quotient bit
            if (!diff[W+1]) begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_next = rem_sh[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - CW'(1);
            done_next = (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start) begin
            dvs_reg <= divisor;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

// ===== hw/rtl/smec_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smec_ctrl: instruction sequencer
// Walks each instruction through reads, checks, execute and result hand-off.
// ----------------------------------------------------------------------------
module smec_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [smec_pkg::CMD_W-1:0] s_cmd,
    input  logic                      s_scan_only,
    output logic                      m_valid,
    input  logic                      m_ready,
    input  smec_pkg::dp_stat_t        stat,
    output smec_pkg::dp_cmd_t         cmd
);

    typedef enum logic [12:0] {
        S_CLEAR = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_DEC   = 13'b0000000000100,
        S_RDA   = 13'b0000000001000,
        S_RDB   = 13'b0000000010000,
        S_EXA   = 13'b0000000100000,
        S_EXB   = 13'b0000001000000,
        S_DIV   = 13'b0000010000000,
        S_WRR   = 13'b0000100000000,
        S_SWAP2 = 13'b0001000000000,
        S_HEAP  = 13'b0010000000000,
        S_LSRCH = 13'b0100000000000,
        S_DONE  = 13'b1000000000000
    } state_t;

    state_t                    state_reg, state_next;
    logic [smec_pkg::CMD_W-1:0] cmd_reg, cmd_next;
    logic                      scan_reg, scan_next;
    smec_pkg::err_t            err_reg, err_next;
    logic                      ov_reg, ov_next;
    logic                      onum_reg, onum_next;
    smec_pkg::npc_sel_t        npc_reg, npc_next;
    logic                      m_valid_reg, m_valid_next;
    smec_pkg::opcode_t         op;
    logic                      is_arith;
    logic                      is_divmod;

    assign op        = smec_pkg::opcode_t'(cmd_reg);
    assign is_divmod = (op == smec_pkg::OP_DIV) || (op == smec_pkg::OP_MOD);
    assign is_arith  = (op == smec_pkg::OP_ADD) || (op == smec_pkg::OP_SUB) ||
                       (op == smec_pkg::OP_MUL) || is_divmod;

    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        scan_next    = scan_reg;
        err_next     = err_reg;
        ov_next      = ov_reg;
        onum_next    = onum_reg;
        npc_next     = npc_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        s_ready      = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (op)
            smec_pkg::OP_SUB: cmd.alu_op = smec_pkg::ALU_SUB;
            smec_pkg::OP_MUL: cmd.alu_op = smec_pkg::ALU_MUL;
            smec_pkg::OP_DIV: cmd.alu_op = smec_pkg::ALU_DIV;
            smec_pkg::OP_MOD: cmd.alu_op = smec_pkg::ALU_MOD;
            default:          cmd.alu_op = smec_pkg::ALU_ADD;
        endcase
        cmd.heap_char = (op == smec_pkg::OP_READC);

        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_step   = 1'b1;
                cmd.heap_we    = 1'b1;
                cmd.heap_wsel  = smec_pkg::HW_CLEAR;
                if (stat.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    cmd_next   = s_cmd;
                    scan_next  = s_scan_only;
                    err_next   = smec_pkg::ERR_NONE;
                    ov_next    = 1'b0;
                    onum_next  = 1'b0;
                    npc_next   = smec_pkg::NPC_PC;
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                state_next = S_DONE;
                if (stat.halt) begin
                    state_next = S_DONE;
                end else if (scan_reg) begin
                    if (op == smec_pkg::OP_MARK) begin
                        cmd.lbl_start = 1'b1;
                        state_next    = S_LSRCH;
                    end
                end else begin
                    cmd.ds_rsel = smec_pkg::DS_R_TOP;
                    unique case (op)
                        smec_pkg::OP_PUSH: begin
                            if (stat.n_full) begin
                                err_next = smec_pkg::ERR_STACK_FULL;
                            end else begin
                                cmd.ds_we    = 1'b1;
                                cmd.ds_wsel  = smec_pkg::DS_W_PUSH;
                                cmd.ds_wdsel = smec_pkg::WD_ARG;
                                cmd.cnt_op   = smec_pkg::CNT_INC;
                            end
                        end
                        smec_pkg::OP_DUP: begin
                            if (stat.n_zero) begin
                                err_next = smec_pkg::ERR_STACK_EMPTY;
                            end else if (stat.n_full) begin
                                err_next = smec_pkg::ERR_STACK_FULL;
                            end else begin
                                cmd.ds_re  = 1'b1;
                                state_next = S_RDA;
                            end
                        end
                        smec_pkg::OP_COPY: begin
                            if (stat.arg_bad) begin
                                err_next = smec_pkg::ERR_RANGE;
                            end else if (stat.n_full) begin
                                err_next = smec_pkg::ERR_STACK_FULL;
                            end else begin
                                cmd.ds_re   = 1'b1;
                                cmd.ds_rsel = smec_pkg::DS_R_COPY;
                                state_next  = S_RDA;
                            end
                        end
                        smec_pkg::OP_SWAP, smec_pkg::OP_ADD, smec_pkg::OP_SUB,
                        smec_pkg::OP_MUL, smec_pkg::OP_DIV, smec_pkg::OP_MOD,
                        smec_pkg::OP_STORE: begin
                            if (stat.n_lt2) begin
                                err_next = smec_pkg::ERR_STACK_EMPTY;
                            end else begin
                                cmd.ds_re  = 1'b1;
                                state_next = S_RDA;
                            end
                        end
                        smec_pkg::OP_SLIDE: begin
                            if (stat.n_zero) begin
                                err_next = smec_pkg::ERR_STACK_EMPTY;
                            end else if (stat.arg_bad) begin
                                err_next = smec_pkg::ERR_RANGE;
                            end else begin
                                cmd.ds_re  = 1'b1;
                                state_next = S_RDA;
                            end
                        end
                        smec_pkg::OP_DISCARD, smec_pkg::OP_WRITEC, smec_pkg::OP_WRITEN,
                        smec_pkg::OP_RETRIEVE, smec_pkg::OP_JZ, smec_pkg::OP_JNEG,
                        smec_pkg::OP_READC, smec_pkg::OP_READN: begin
                            if (stat.n_zero) begin
                                err_next = smec_pkg::ERR_STACK_EMPTY;
                            end else begin
                                cmd.ds_re  = 1'b1;
                                state_next = S_RDA;
                            end
                        end
                        smec_pkg::OP_MARK: begin
                            state_next = S_DONE;
                        end
                        smec_pkg::OP_CALL, smec_pkg::OP_JUMP: begin
                            cmd.lbl_start = 1'b1;
                            state_next    = S_LSRCH;
                        end
                        smec_pkg::OP_RET: begin
                            if (stat.rc_zero) begin
                                err_next = smec_pkg::ERR_RET_EMPTY;
                            end else begin
                                cmd.rs_re  = 1'b1;
                                cmd.rc_op  = smec_pkg::RC_DEC;
                                npc_next   = smec_pkg::NPC_RET;
                            end
                        end
                        smec_pkg::OP_END: begin
                            cmd.halt_set = 1'b1;
                        end
                        default: begin
                            err_next = smec_pkg::ERR_BAD_OP;
                        end
                    endcase
                end
            end
            S_RDA: begin
                cmd.cap_a = 1'b1;
                if (is_arith || op == smec_pkg::OP_SWAP || op == smec_pkg::OP_STORE) begin
                    cmd.ds_re   = 1'b1;
                    cmd.ds_rsel = smec_pkg::DS_R_SECOND;
                    state_next  = S_RDB;
                end else begin
                    state_next = S_EXA;
                end
            end
            S_RDB: begin
                cmd.cap_b  = 1'b1;
                state_next = S_EXB;
            end
            S_EXA: begin
                state_next = S_DONE;
                unique case (op)
                    smec_pkg::OP_DUP, smec_pkg::OP_COPY: begin
                        cmd.ds_we    = 1'b1;
                        cmd.ds_wsel  = smec_pkg::DS_W_PUSH;
                        cmd.ds_wdsel = smec_pkg::WD_A;
                        cmd.cnt_op   = smec_pkg::CNT_INC;
                    end
                    smec_pkg::OP_WRITEC, smec_pkg::OP_WRITEN: begin
                        cmd.cnt_op = smec_pkg::CNT_DEC;
                        ov_next    = 1'b1;
                        onum_next  = (op == smec_pkg::OP_WRITEN);
                    end
                    smec_pkg::OP_SLIDE: begin
                        cmd.ds_we    = 1'b1;
                        cmd.ds_wsel  = smec_pkg::DS_W_SLIDE;
                        cmd.ds_wdsel = smec_pkg::WD_A;
                        cmd.cnt_op   = smec_pkg::CNT_SLIDE;
                    end
                    smec_pkg::OP_RETRIEVE: begin
                        if (!stat.a_heap_ok) begin
                            err_next = smec_pkg::ERR_HEAP_ADDR;
                        end else begin
                            cmd.heap_re = 1'b1;
                            state_next  = S_HEAP;
                        end
                    end
                    smec_pkg::OP_JZ, smec_pkg::OP_JNEG: begin
                        if ((op == smec_pkg::OP_JZ) ? stat.a_zero : stat.a_neg) begin
                            cmd.lbl_start = 1'b1;
                            state_next    = S_LSRCH;
                        end else begin
                            cmd.cnt_op = smec_pkg::CNT_DEC;
                        end
                    end
                    smec_pkg::OP_READC, smec_pkg::OP_READN: begin
                        if (!stat.a_heap_ok) begin
                            err_next = smec_pkg::ERR_HEAP_ADDR;
                        end else begin
                            cmd.heap_we   = 1'b1;
                            cmd.heap_wsel = smec_pkg::HW_READ;
                            cmd.cnt_op    = smec_pkg::CNT_DEC;
                        end
                    end
                    default: begin
                        // discard
                        cmd.cnt_op = smec_pkg::CNT_DEC;
                    end
                endcase
            end
            S_EXB: begin
                state_next = S_DONE;
                if (op == smec_pkg::OP_SWAP) begin
                    cmd.ds_we    = 1'b1;
                    cmd.ds_wsel  = smec_pkg::DS_W_TOP;
                    cmd.ds_wdsel = smec_pkg::WD_B;
                    state_next   = S_SWAP2;
                end else if (op == smec_pkg::OP_STORE) begin
                    if (!stat.b_heap_ok) begin
                        err_next = smec_pkg::ERR_HEAP_ADDR;
                    end else begin
                        cmd.heap_we   = 1'b1;
                        cmd.heap_wsel = smec_pkg::HW_STORE;
                        cmd.cnt_op    = smec_pkg::CNT_DEC2;
                    end
                end else if (is_divmod) begin
                    if (stat.a_zero) begin
                        err_next = smec_pkg::ERR_DIV_ZERO;
                    end else begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                end else begin
                    cmd.cap_r  = 1'b1;
                    state_next = S_WRR;
                end
            end
            S_DIV: begin
                if (stat.div_done) begin
                    cmd.cap_r  = 1'b1;
                    state_next = S_WRR;
                end
            end
            S_WRR: begin
                cmd.ds_we    = 1'b1;
                cmd.ds_wsel  = smec_pkg::DS_W_SECOND;
                cmd.ds_wdsel = smec_pkg::WD_R;
                cmd.cnt_op   = smec_pkg::CNT_DEC;
                state_next   = S_DONE;
            end
            S_SWAP2: begin
                cmd.ds_we    = 1'b1;
                cmd.ds_wsel  = smec_pkg::DS_W_SECOND;
                cmd.ds_wdsel = smec_pkg::WD_A;
                state_next   = S_DONE;
            end
            S_HEAP: begin
                cmd.ds_we    = 1'b1;
                cmd.ds_wsel  = smec_pkg::DS_W_TOP;
                cmd.ds_wdsel = smec_pkg::WD_HEAP;
                state_next   = S_DONE;
            end
            S_LSRCH: begin
                cmd.lbl_run = 1'b1;
                if (stat.lbl_hit) begin
                    state_next = S_DONE;
                    if (!scan_reg) begin
                        if (op == smec_pkg::OP_CALL && stat.rc_full) begin
                            err_next = smec_pkg::ERR_RET_FULL;
                        end else begin
                            npc_next = smec_pkg::NPC_LABEL;
                            if (op == smec_pkg::OP_CALL) begin
                                cmd.rs_we = 1'b1;
                                cmd.rc_op = smec_pkg::RC_INC;
                            end
                            if (op == smec_pkg::OP_JZ || op == smec_pkg::OP_JNEG) begin
                                cmd.cnt_op = smec_pkg::CNT_DEC;
                            end
                        end
                    end
                end else if (stat.lbl_miss) begin
                    state_next = S_DONE;
                    if (scan_reg) begin
                        if (stat.lbl_full) begin
                            err_next = smec_pkg::ERR_LABEL_FULL;
                        end else begin
                            cmd.lbl_we = 1'b1;
                        end
                    end else begin
                        err_next = smec_pkg::ERR_NO_LABEL;
                    end
                end
            end
            S_DONE: begin
                cmd.res_npc  = npc_reg;
                cmd.res_ov   = ov_reg;
                cmd.res_onum = onum_reg;
                cmd.res_err  = err_reg;
                if (!m_valid_reg || m_ready) begin
                    cmd.res_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            m_valid_reg <= 1'b0;
            err_reg     <= smec_pkg::ERR_NONE;
            ov_reg      <= 1'b0;
            onum_reg    <= 1'b0;
            npc_reg     <= smec_pkg::NPC_PC;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            err_reg     <= err_next;
            ov_reg      <= ov_next;
            onum_reg    <= onum_next;
            npc_reg     <= npc_next;
        end
        cmd_reg  <= cmd_next;
        scan_reg <= scan_next;
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== hw/rtl/smec_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smec_dpath: stack machine datapath
// Stores, counters, operand and result registers driven by sequencer commands.
// ----------------------------------------------------------------------------
module smec_dpath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [smec_pkg::DATA_W-1:0]   s_arg,
    input  logic [smec_pkg::PC_WIDTH-1:0] s_pc_next,
    input  logic [smec_pkg::DATA_W-1:0]   s_in_value,
    input  smec_pkg::dp_cmd_t            cmd,
    output smec_pkg::dp_stat_t           stat,
    output logic [smec_pkg::PC_WIDTH-1:0] m_next_pc,
    output logic                         m_out_valid,
    output logic                         m_out_is_number,
    output logic [smec_pkg::DATA_W-1:0]   m_out_value,
    output logic                         m_halted,
    output logic [smec_pkg::ERR_W-1:0]    m_error
);

    localparam int DW  = smec_pkg::DATA_W;
    localparam int PW  = smec_pkg::PC_WIDTH;
    localparam int SAW = smec_pkg::SAW;
    localparam int SCW = smec_pkg::SCW;
    localparam int HAW = smec_pkg::HAW;
    localparam int RAW = smec_pkg::RAW;
    localparam int RCW = smec_pkg::RCW;
    localparam int LAW = smec_pkg::LAW;
    localparam int LCW = smec_pkg::LCW;

    logic [DW-1:0]  arg_reg, pcn_unused;
    logic [PW-1:0]  pcn_reg;
    logic [DW-1:0]  inv_reg;
    logic [DW-1:0]  a_reg, b_reg, r_reg, r_next;
    logic [PW-1:0]  tgt_reg;
    logic [SCW-1:0] n_reg, n_next;
    logic [RCW-1:0] rc_reg, rc_next;
    logic [LCW-1:0] lc_reg;
    logic [LCW-1:0] lidx_reg;
    logic           lpend_reg;
    logic           halt_reg;
    logic [HAW-1:0] clr_reg;

    logic [PW-1:0]  res_pc_reg;
    logic           res_ov_reg, res_onum_reg, res_halt_reg;
    logic [DW-1:0]  res_val_reg;
    logic [smec_pkg::ERR_W-1:0] res_err_reg;

    logic [SAW-1:0] ds_raddr, ds_waddr;
    logic [DW-1:0]  ds_wdata, ds_rdata;
    logic [SCW-1:0] n_copy;
    logic [HAW-1:0] heap_waddr;
    logic [DW-1:0]  heap_wdata, heap_rdata;
    logic [PW-1:0]  rs_rdata;
    logic [DW-1:0]  key_rdata;
    logic [PW-1:0]  tgt_rdata;
    logic           lbl_re;
    logic           lbl_hit;
    logic [DW-1:0]  div_quo, div_rem;
    logic           div_done;
    logic [DW-1:0]  in_char;

    assign pcn_unused = '0;
    assign n_copy     = n_reg - SCW'(arg_reg) - SCW'(1);
    assign in_char    = {{(DW-8){inv_reg[7]}}, inv_reg[7:0]};

    // data stack
    always_comb begin
        unique case (cmd.ds_rsel)
            smec_pkg::DS_R_SECOND: ds_raddr = SAW'(n_reg - SCW'(2));
            smec_pkg::DS_R_COPY:   ds_raddr = n_copy[SAW-1:0];
            default:               ds_raddr = SAW'(n_reg - SCW'(1));
        endcase
        unique case (cmd.ds_wsel)
            smec_pkg::DS_W_PUSH:   ds_waddr = n_reg[SAW-1:0];
            smec_pkg::DS_W_TOP:    ds_waddr = SAW'(n_reg - SCW'(1));
            smec_pkg::DS_W_SECOND: ds_waddr = SAW'(n_reg - SCW'(2));
            default:               ds_waddr = n_copy[SAW-1:0];
        endcase
        unique case (cmd.ds_wdsel)
            smec_pkg::WD_A:    ds_wdata = a_reg;
            smec_pkg::WD_B:    ds_wdata = b_reg;
            smec_pkg::WD_R:    ds_wdata = r_reg;
            smec_pkg::WD_HEAP: ds_wdata = heap_rdata;
            default:           ds_wdata = arg_reg;
        endcase
    end

    smec_ram #(.WIDTH(DW), .DEPTH(smec_pkg::STACK_DEPTH)) u_ds (
        .aclk(aclk), .we(cmd.ds_we), .waddr(ds_waddr), .wdata(ds_wdata),
        .re(cmd.ds_re), .raddr(ds_raddr), .rdata(ds_rdata)
    );

    // heap
    always_comb begin
        unique case (cmd.heap_wsel)
            smec_pkg::HW_STORE: begin
                heap_waddr = b_reg[HAW-1:0];
                heap_wdata = a_reg;
            end
            smec_pkg::HW_READ: begin
                heap_waddr = a_reg[HAW-1:0];
                heap_wdata = cmd.heap_char ? in_char : inv_reg;
            end
            default: begin
                heap_waddr = clr_reg;
                heap_wdata = '0;
            end
        endcase
    end

    smec_ram #(.WIDTH(DW), .DEPTH(smec_pkg::HEAP_DEPTH)) u_heap (
        .aclk(aclk), .we(cmd.heap_we), .waddr(heap_waddr), .wdata(heap_wdata),
        .re(cmd.heap_re), .raddr(a_reg[HAW-1:0]), .rdata(heap_rdata)
    );

    // return stack
    smec_ram #(.WIDTH(PW), .DEPTH(smec_pkg::CALL_DEPTH)) u_rs (
        .aclk(aclk), .we(cmd.rs_we), .waddr(rc_reg[RAW-1:0]), .wdata(pcn_reg),
        .re(cmd.rs_re), .raddr(RAW'(rc_reg - RCW'(1))), .rdata(rs_rdata)
    );

    // label table, swept one entry a cycle
    assign lbl_re  = cmd.lbl_run && (lidx_reg < lc_reg);
    assign lbl_hit = lpend_reg && (key_rdata == arg_reg);

    smec_ram #(.WIDTH(DW), .DEPTH(smec_pkg::LABEL_COUNT)) u_lkey (
        .aclk(aclk), .we(cmd.lbl_we), .waddr(lc_reg[LAW-1:0]), .wdata(arg_reg),
        .re(lbl_re), .raddr(lidx_reg[LAW-1:0]), .rdata(key_rdata)
    );

    smec_ram #(.WIDTH(PW), .DEPTH(smec_pkg::LABEL_COUNT)) u_ltgt (
        .aclk(aclk), .we(cmd.lbl_we), .waddr(lc_reg[LAW-1:0]), .wdata(pcn_reg),
        .re(lbl_re), .raddr(lidx_reg[LAW-1:0]), .rdata(tgt_rdata)
    );

    smec_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.div_start),
        .dividend(smec_pkg::mag32(b_reg)), .divisor(smec_pkg::mag32(a_reg)),
        .done(div_done), .quo(div_quo), .rem(div_rem)
    );

    always_comb begin
        unique case (cmd.alu_op)
            smec_pkg::ALU_SUB: r_next = b_reg - a_reg;
            smec_pkg::ALU_MUL: r_next = DW'(b_reg * a_reg);
            smec_pkg::ALU_DIV: r_next = (a_reg[DW-1] ^ b_reg[DW-1]) ? (DW'(0) - div_quo)
                                                                   : div_quo;
            smec_pkg::ALU_MOD: r_next = b_reg[DW-1] ? (DW'(0) - div_rem) : div_rem;
            default:           r_next = b_reg + a_reg;
        endcase
        unique case (cmd.cnt_op)
            smec_pkg::CNT_INC:   n_next = n_reg + SCW'(1);
            smec_pkg::CNT_DEC:   n_next = n_reg - SCW'(1);
            smec_pkg::CNT_DEC2:  n_next = n_reg - SCW'(2);
            smec_pkg::CNT_SLIDE: n_next = n_reg - SCW'(arg_reg);
            default:             n_next = n_reg;
        endcase
        unique case (cmd.rc_op)
            smec_pkg::RC_INC: rc_next = rc_reg + RCW'(1);
            smec_pkg::RC_DEC: rc_next = rc_reg - RCW'(1);
            default:          rc_next = rc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg     <= '0;
            rc_reg    <= '0;
            lc_reg    <= '0;
            halt_reg  <= 1'b0;
            clr_reg   <= '0;
            lidx_reg  <= '0;
            lpend_reg <= 1'b0;
        end else begin
            n_reg  <= n_next;
            rc_reg <= rc_next;
            if (cmd.lbl_we) begin
                lc_reg <= lc_reg + LCW'(1);
            end
            if (cmd.halt_set) begin
                halt_reg <= 1'b1;
            end
            if (cmd.clr_step) begin
                clr_reg <= clr_reg + HAW'(1);
            end
            if (cmd.lbl_start) begin
                lidx_reg  <= '0;
                lpend_reg <= 1'b0;
            end else if (cmd.lbl_run) begin
                lpend_reg <= lbl_re;
                if (lbl_re) begin
                    lidx_reg <= lidx_reg + LCW'(1);
                end
            end
        end
        if (cmd.latch) begin
            arg_reg <= s_arg;
            pcn_reg <= s_pc_next;
            inv_reg <= s_in_value;
        end
        if (cmd.cap_a) begin
            a_reg <= ds_rdata;
        end
        if (cmd.cap_b) begin
            b_reg <= ds_rdata;
        end
        if (cmd.cap_r) begin
            r_reg <= r_next;
        end
        if (cmd.lbl_run && lbl_hit) begin
            tgt_reg <= tgt_rdata;
        end
        if (cmd.res_load) begin
            unique case (cmd.res_npc)
                smec_pkg::NPC_LABEL: res_pc_reg <= tgt_reg;
                smec_pkg::NPC_RET:   res_pc_reg <= rs_rdata;
                default:             res_pc_reg <= pcn_reg;
            endcase
            res_ov_reg   <= cmd.res_ov;
            res_onum_reg <= cmd.res_onum;
            res_val_reg  <= cmd.res_ov ? a_reg : pcn_unused;
            res_halt_reg <= halt_reg;
            res_err_reg  <= cmd.res_err;
        end
    end

    always_comb begin
        stat.n_zero    = (n_reg == '0);
        stat.n_lt2     = (n_reg < SCW'(2));
        stat.n_full    = (n_reg >= SCW'(smec_pkg::STACK_DEPTH));
        stat.arg_bad   = (arg_reg >= DW'(n_reg));
        stat.rc_zero   = (rc_reg == '0);
        stat.rc_full   = (rc_reg >= RCW'(smec_pkg::CALL_DEPTH));
        stat.lbl_full  = (lc_reg >= LCW'(smec_pkg::LABEL_COUNT));
        stat.lbl_hit   = lbl_hit;
        stat.lbl_miss  = !lpend_reg && (lidx_reg >= lc_reg);
        stat.a_zero    = (a_reg == '0);
        stat.a_neg     = a_reg[DW-1];
        stat.a_heap_ok = (a_reg < DW'(smec_pkg::HEAP_DEPTH));
        stat.b_heap_ok = (b_reg < DW'(smec_pkg::HEAP_DEPTH));
        stat.div_done  = div_done;
        stat.clr_last  = (clr_reg == HAW'(smec_pkg::HEAP_DEPTH - 1));
        stat.halt      = halt_reg;
    end

    assign m_next_pc       = res_pc_reg;
    assign m_out_valid     = res_ov_reg;
    assign m_out_is_number = res_onum_reg;
    assign m_out_value     = res_val_reg;
    assign m_halted        = res_halt_reg;
    assign m_error         = res_err_reg;

endmodule

// ===== hw/rtl/stack_machine_execute_core_unit.sv =====
`timescale 1ns / 1ps
// Paths: push, end, ret, mark, scan-pass no-ops and decode errors go from decode straight to
//   the result; stack reads and writes pass through operand reads and execute; div/mod also
//   wait on the 32-step divider; label lookups sweep the table (one table entry per cycle)
//   after the decode or stack read.
// Throughput: one instruction at a time; the next beat is taken in the cycle after the result
//   is loaded, and a result still waiting in the output register holds the sequencer.
// Reset: synchronous, active low; afterwards all HEAP_DEPTH (1024) heap words are cleared
//   with s_ready low.
// ----------------------------------------------------------------------------
// stack_machine_execute_core_unit: stack machine execute core
// Executes one stack-machine instruction per input beat and returns one result
// beat with next pc, optional output, halt and error.
// ----------------------------------------------------------------------------
module stack_machine_execute_core_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [smec_pkg::CMD_W-1:0]    s_cmd,
    input  logic [smec_pkg::DATA_W-1:0]   s_arg,
    input  logic [smec_pkg::PC_WIDTH-1:0] s_pc_next,
    input  logic [smec_pkg::DATA_W-1:0]   s_in_value,
    input  logic                         s_scan_only,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [smec_pkg::PC_WIDTH-1:0] m_next_pc,
    output logic                         m_out_valid,
    output logic                         m_out_is_number,
    output logic [smec_pkg::DATA_W-1:0]   m_out_value,
    output logic                         m_halted,
    output logic [smec_pkg::ERR_W-1:0]    m_error
);

    // command and status between sequencer and datapath
    smec_pkg::dp_cmd_t  dp_cmd;
    smec_pkg::dp_stat_t dp_stat;

    // sequencer: clearing pass, decode, checks in priority order, result hand-off
    smec_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_scan_only (s_scan_only),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .stat        (dp_stat),
        .cmd         (dp_cmd)
    );

    // datapath: data stack, heap, return stack, label table, divider, result beat
    smec_dpath u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_arg           (s_arg),
        .s_pc_next       (s_pc_next),
        .s_in_value      (s_in_value),
        .cmd             (dp_cmd),
        .stat            (dp_stat),
        .m_next_pc       (m_next_pc),
        .m_out_valid     (m_out_valid),
        .m_out_is_number (m_out_is_number),
        .m_out_value     (m_out_value),
        .m_halted        (m_halted),
        .m_error         (m_error)
    );

endmodule

// ===== hw/rtl/smec_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smec_checker: port-level checks for the execute core
// Watches result beats and reset behavior from the top-level ports.
// ----------------------------------------------------------------------------
module smec_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [smec_pkg::PC_WIDTH-1:0] m_next_pc,
    input logic                         m_out_valid,
    input logic                         m_halted,
    input logic [smec_pkg::ERR_W-1:0]    m_error
);

    // stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_next_pc) && $stable(m_error))
        else $error("result beat changed while stalled");

    // output only on a clean, running instruction
    a_out_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_valid |-> m_error == smec_pkg::ERR_NONE && !m_halted)
        else $error("output with error or halt");

    // a halted machine reports no error
    a_halt_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_halted |-> m_error == smec_pkg::ERR_NONE)
        else $error("error reported while halted");

    // heap clearing blocks input right after reset
    a_clear: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input taken during heap clear");

endmodule

bind stack_machine_execute_core_unit smec_checker u_chk (.*);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the stack machine execute core
// Builds an instruction stream (label scan, directed corner cases, then
// shaped random programs), predicts every result beat with a local machine
// model and checks the result channel beat by beat under random stalls.
// ----------------------------------------------------------------------------
module tb;

    localparam int CMD_W       = smec_pkg::CMD_W;
    localparam int DATA_W      = smec_pkg::DATA_W;
    localparam int PC_WIDTH    = smec_pkg::PC_WIDTH;
    localparam int ERR_W       = smec_pkg::ERR_W;
    localparam int STACK_DEPTH = smec_pkg::STACK_DEPTH;
    localparam int HEAP_DEPTH  = smec_pkg::HEAP_DEPTH;
    localparam int CALL_DEPTH  = smec_pkg::CALL_DEPTH;
    localparam int LABEL_COUNT = smec_pkg::LABEL_COUNT;

    typedef struct {
        logic [CMD_W-1:0]    cmd;
        logic [DATA_W-1:0]   arg;
        logic [PC_WIDTH-1:0] pcn;
        logic [DATA_W-1:0]   inv;
        logic                scan;
    } instr_t;

    typedef struct {
        logic [PC_WIDTH-1:0] npc;
        logic                ov;
        logic                onum;
        logic [DATA_W-1:0]   oval;
        logic                halted;
        logic [ERR_W-1:0]    err;
    } outcome_t;

    localparam logic [31:0] INT_MIN = 32'h8000_0000;
    localparam logic [31:0] INT_MAX = 32'h7fff_ffff;
    localparam int NUM_INSTR = 1500;

    logic aclk, aresetn;
    logic s_valid, s_ready, s_scan_only;
    logic [CMD_W-1:0]    s_cmd;
    logic [DATA_W-1:0]   s_arg, s_in_value;
    logic [PC_WIDTH-1:0] s_pc_next;
    logic m_valid, m_ready, m_out_valid, m_out_is_number, m_halted;
    logic [PC_WIDTH-1:0] m_next_pc;
    logic [DATA_W-1:0]   m_out_value;
    logic [ERR_W-1:0]    m_error;

    stack_machine_execute_core_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_cmd(s_cmd), .s_arg(s_arg), .s_pc_next(s_pc_next),
        .s_in_value(s_in_value), .s_scan_only(s_scan_only),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_next_pc(m_next_pc), .m_out_valid(m_out_valid),
        .m_out_is_number(m_out_is_number), .m_out_value(m_out_value),
        .m_halted(m_halted), .m_error(m_error)
    );

    // Instruction beats still to send, and the result beats owed by the core.
    instr_t   program_q[$];
    outcome_t owed_results[$];
    int       total_instr;
    int       sent_cnt;
    int       mismatches;

    // Local copy of the machine state.
    logic [31:0] mdl_stack [STACK_DEPTH];
    int unsigned mdl_depth;
    logic [31:0] mdl_heap [HEAP_DEPTH];
    logic [15:0] mdl_rets [CALL_DEPTH];
    int unsigned mdl_rdepth;
    logic [31:0] mdl_lkey [LABEL_COUNT];
    logic [15:0] mdl_ltgt [LABEL_COUNT];
    bit          mdl_lvld [LABEL_COUNT];
    bit          mdl_halt;

    function automatic int label_slot(logic [31:0] key);
        for (int i = 0; i < LABEL_COUNT; i++)
            if (mdl_lvld[i] && mdl_lkey[i] == key) return i;
        return -1;
    endfunction

    function automatic bit heap_addr_ok(logic [31:0] x);
        return !x[31] && x < HEAP_DEPTH;
    endfunction

    // Execute one instruction on the local machine and return its result.
    task automatic execute_instr(input instr_t it, output outcome_t r);
        int li;
        int fs;
        int unsigned n;
        logic [31:0] a, b, q, ma, mb;
        n = mdl_depth;
        r.npc = it.pcn; r.ov = 0; r.onum = 0; r.oval = '0; r.err = smec_pkg::ERR_NONE;
        if (mdl_halt) begin
        end else if (it.scan) begin
            if (it.cmd == smec_pkg::OP_MARK && label_slot(it.arg) < 0) begin
                fs = -1;
                for (int i = LABEL_COUNT - 1; i >= 0; i--)
                    if (!mdl_lvld[i]) fs = i;
                if (fs < 0) r.err = smec_pkg::ERR_LABEL_FULL;
                else begin
                    mdl_lkey[fs] = it.arg; mdl_ltgt[fs] = it.pcn; mdl_lvld[fs] = 1;
                end
            end
        end else begin
            case (smec_pkg::opcode_t'(it.cmd))
                smec_pkg::OP_PUSH: begin
                    if (n >= STACK_DEPTH) r.err = smec_pkg::ERR_STACK_FULL;
                    else begin mdl_stack[n] = it.arg; mdl_depth++; end
                end
                smec_pkg::OP_DUP: begin
                    if (n == 0) r.err = smec_pkg::ERR_STACK_EMPTY;
                    else if (n >= STACK_DEPTH) r.err = smec_pkg::ERR_STACK_FULL;
                    else begin mdl_stack[n] = mdl_stack[n-1]; mdl_depth++; end
                end
                smec_pkg::OP_COPY: begin
                    if (it.arg[31] || it.arg >= n) r.err = smec_pkg::ERR_RANGE;
                    else if (n >= STACK_DEPTH) r.err = smec_pkg::ERR_STACK_FULL;
                    else begin mdl_stack[n] = mdl_stack[n-1-it.arg]; mdl_depth++; end
                end
                smec_pkg::OP_SWAP: begin
                    if (n < 2) r.err = smec_pkg::ERR_STACK_EMPTY;
                    else begin
                        a = mdl_stack[n-1];
                        mdl_stack[n-1] = mdl_stack[n-2];
                        mdl_stack[n-2] = a;
                    end
                end
                smec_pkg::OP_DISCARD, smec_pkg::OP_WRITEC, smec_pkg::OP_WRITEN: begin
                    if (n == 0) r.err = smec_pkg::ERR_STACK_EMPTY;
                    else begin
                        if (it.cmd != smec_pkg::OP_DISCARD) begin
                            r.ov = 1;
                            r.onum = (it.cmd == smec_pkg::OP_WRITEN);
                            r.oval = mdl_stack[n-1];
                        end
                        mdl_depth--;
                    end
                end
                smec_pkg::OP_SLIDE: begin
                    if (n == 0) r.err = smec_pkg::ERR_STACK_EMPTY;
                    else if (it.arg[31] || it.arg > n - 1) r.err = smec_pkg::ERR_RANGE;
                    else begin
                        mdl_stack[n-1-it.arg] = mdl_stack[n-1];
                        mdl_depth = n - it.arg;
                    end
                end
                smec_pkg::OP_ADD, smec_pkg::OP_SUB, smec_pkg::OP_MUL,
                smec_pkg::OP_DIV, smec_pkg::OP_MOD: begin
                    if (n < 2) r.err = smec_pkg::ERR_STACK_EMPTY;
                    else begin
                        a = mdl_stack[n-1];
                        b = mdl_stack[n-2];
                        ma = a[31] ? -a : a;
                        mb = b[31] ? -b : b;
                        if ((it.cmd == smec_pkg::OP_DIV || it.cmd == smec_pkg::OP_MOD)
                            && a == 0)
                            r.err = smec_pkg::ERR_DIV_ZERO;
                        else begin
                            case (smec_pkg::opcode_t'(it.cmd))
                                smec_pkg::OP_ADD: q = b + a;
                                smec_pkg::OP_SUB: q = b - a;
                                smec_pkg::OP_MUL: q = b * a;
                                smec_pkg::OP_DIV: begin
                                    q = mb / ma;
                                    if (a[31] ^ b[31]) q = -q;
                                end
                                default: begin
                                    q = mb % ma;
                                    if (b[31]) q = -q;
                                end
                            endcase
                            mdl_stack[n-2] = q;
                            mdl_depth--;
                        end
                    end
                end
                smec_pkg::OP_STORE: begin
                    if (n < 2) r.err = smec_pkg::ERR_STACK_EMPTY;
                    else if (!heap_addr_ok(mdl_stack[n-2])) r.err = smec_pkg::ERR_HEAP_ADDR;
                    else begin
                        mdl_heap[mdl_stack[n-2]] = mdl_stack[n-1];
                        mdl_depth -= 2;
                    end
                end
                smec_pkg::OP_RETRIEVE: begin
                    if (n == 0) r.err = smec_pkg::ERR_STACK_EMPTY;
                    else if (!heap_addr_ok(mdl_stack[n-1])) r.err = smec_pkg::ERR_HEAP_ADDR;
                    else mdl_stack[n-1] = mdl_heap[mdl_stack[n-1]];
                end
                smec_pkg::OP_MARK: begin
                end
                smec_pkg::OP_CALL, smec_pkg::OP_JUMP: begin
                    li = label_slot(it.arg);
                    if (li < 0) r.err = smec_pkg::ERR_NO_LABEL;
                    else if (it.cmd == smec_pkg::OP_CALL && mdl_rdepth >= CALL_DEPTH)
                        r.err = smec_pkg::ERR_RET_FULL;
                    else begin
                        if (it.cmd == smec_pkg::OP_CALL) begin
                            mdl_rets[mdl_rdepth] = it.pcn; mdl_rdepth++;
                        end
                        r.npc = mdl_ltgt[li];
                    end
                end
                smec_pkg::OP_JZ, smec_pkg::OP_JNEG: begin
                    if (n == 0) r.err = smec_pkg::ERR_STACK_EMPTY;
                    else begin
                        a = mdl_stack[n-1];
                        li = 0;
                        if ((it.cmd == smec_pkg::OP_JZ) ? (a == 0) : a[31]) begin
                            li = label_slot(it.arg);
                            if (li < 0) r.err = smec_pkg::ERR_NO_LABEL;
                            else r.npc = mdl_ltgt[li];
                        end
                        if (li >= 0) mdl_depth--;
                    end
                end
                smec_pkg::OP_RET: begin
                    if (mdl_rdepth == 0) r.err = smec_pkg::ERR_RET_EMPTY;
                    else begin mdl_rdepth--; r.npc = mdl_rets[mdl_rdepth]; end
                end
                smec_pkg::OP_END: mdl_halt = 1;
                smec_pkg::OP_READC, smec_pkg::OP_READN: begin
                    if (n == 0) r.err = smec_pkg::ERR_STACK_EMPTY;
                    else if (!heap_addr_ok(mdl_stack[n-1])) r.err = smec_pkg::ERR_HEAP_ADDR;
                    else begin
                        q = it.inv;
                        if (it.cmd == smec_pkg::OP_READC) q = {{24{it.inv[7]}}, it.inv[7:0]};
                        mdl_heap[mdl_stack[n-1]] = q;
                        mdl_depth--;
                    end
                end
                default: r.err = smec_pkg::ERR_BAD_OP;
            endcase
        end
        r.halted = mdl_halt;
    endtask

    // Queue an instruction beat and the result it must produce.
    task automatic issue(input logic [CMD_W-1:0] cmd, input logic [31:0] arg,
                         input logic scan = 1'b0, input logic [31:0] inv = $urandom);
        instr_t it;
        outcome_t r;
        it.cmd = cmd; it.arg = arg; it.pcn = PC_WIDTH'($urandom); it.inv = inv;
        it.scan = scan;
        execute_instr(it, r);
        program_q = {program_q, it};
        owed_results = {owed_results, r};
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0: return 32'd0;
            1: return INT_MIN;
            2: return INT_MAX;
            3: return 32'hffff_ffff;
            4, 5: return $urandom_range(HEAP_DEPTH - 1);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_addr();
        if ($urandom_range(9) != 0) return $urandom_range(HEAP_DEPTH - 1);
        case ($urandom_range(3))
            0: return 32'hffff_ffff;
            1: return HEAP_DEPTH;
            2: return INT_MIN;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_label();
        if ($urandom_range(9) == 0) return $urandom;
        return mdl_lkey[$urandom_range(LABEL_COUNT - 1)];
    endfunction

    task automatic build_program();
        int unsigned n;
        int sel;
        bit stack_burst_done, call_burst_done;
        stack_burst_done = 0;
        call_burst_done = 0;
        // Directed: label scan, duplicate binding, scan-pass no-ops.
        issue(smec_pkg::OP_MARK, 32'd0, 1'b1);
        issue(smec_pkg::OP_MARK, INT_MIN, 1'b1);
        issue(smec_pkg::OP_MARK, INT_MAX, 1'b1);
        issue(smec_pkg::OP_MARK, 32'd0, 1'b1);
        issue(5'd31, 32'd5, 1'b1);
        issue(smec_pkg::OP_PUSH, 32'd7, 1'b1);
        // Directed: empty stacks, missing label, bad opcodes, mark outside scan.
        issue(smec_pkg::OP_MARK, 32'd99);
        issue(smec_pkg::OP_DISCARD, 32'd0);
        issue(smec_pkg::OP_ADD, 32'd0);
        issue(smec_pkg::OP_RET, 32'd0);
        issue(smec_pkg::OP_JUMP, 32'h1234_5678);
        issue(5'd24, 32'd0);
        issue(5'd31, 32'd0);
        // Directed: division wrap, mod of INT_MIN by -1, divide by zero, range errors.
        issue(smec_pkg::OP_PUSH, INT_MIN);
        issue(smec_pkg::OP_PUSH, 32'hffff_ffff);
        issue(smec_pkg::OP_DIV, 32'd0);
        issue(smec_pkg::OP_PUSH, 32'hffff_ffff);
        issue(smec_pkg::OP_MOD, 32'd0);
        issue(smec_pkg::OP_PUSH, 32'd0);
        issue(smec_pkg::OP_DIV, 32'd0);
        issue(smec_pkg::OP_COPY, 32'hffff_ffff);
        issue(smec_pkg::OP_SLIDE, 32'd9);
        issue(smec_pkg::OP_CALL, 32'd0);
        issue(smec_pkg::OP_RET, 32'd0);
        issue(smec_pkg::OP_WRITEN, 32'd0);

        // Fill the label table through a scan pass, with noise and overflow marks.
        for (int i = 0; i < 90; i++) begin
            if ($urandom_range(4) == 0) issue(CMD_W'($urandom), $urandom, 1'b1);
            else issue(smec_pkg::OP_MARK,
                       ($urandom_range(3) == 0) ? pick_word() : $urandom, 1'b1);
        end

        while (program_q.size() < NUM_INSTR - 10) begin
            n = mdl_depth;
            sel = $urandom_range(99);
            if (!stack_burst_done && program_q.size() > 600) begin
                // Run the stack into its ceiling, then collapse it with one slide.
                stack_burst_done = 1;
                while (mdl_depth < STACK_DEPTH) issue(smec_pkg::OP_PUSH, pick_word());
                issue(smec_pkg::OP_PUSH, 32'd1);
                issue(smec_pkg::OP_DUP, 32'd0);
                issue(smec_pkg::OP_COPY, 32'd0);
                issue(smec_pkg::OP_SLIDE, STACK_DEPTH - 1);
            end else if (!call_burst_done && program_q.size() > 1000) begin
                call_burst_done = 1;
                for (int i = 0; i < CALL_DEPTH + 2; i++)
                    issue(smec_pkg::OP_CALL, mdl_lkey[i % 8]);
                for (int i = 0; i < CALL_DEPTH + 2; i++) issue(smec_pkg::OP_RET, 32'd0);
            end else if (n > 200) begin
                issue(smec_pkg::OP_SLIDE, $urandom_range(n - 1));
            end else if (sel < 25) begin
                issue(smec_pkg::OP_PUSH, pick_word());
            end else if (sel < 45) begin
                if (n < 2 && $urandom_range(3) != 0) issue(smec_pkg::OP_PUSH, pick_word());
                else issue(CMD_W'(smec_pkg::OP_ADD + $urandom_range(4)), $urandom);
            end else if (sel < 60) begin
                case ($urandom_range(4))
                    0: issue(smec_pkg::OP_DUP, $urandom);
                    1: issue(smec_pkg::OP_COPY,
                             ($urandom_range(9) == 0) ? $urandom : $urandom_range(n));
                    2: issue(smec_pkg::OP_SWAP, $urandom);
                    3: issue(smec_pkg::OP_DISCARD, $urandom);
                    default: issue(smec_pkg::OP_SLIDE,
                        ($urandom_range(9) == 0) ? $urandom : $urandom_range(n));
                endcase
            end else if (sel < 72) begin
                issue(smec_pkg::OP_PUSH, pick_addr());
                case ($urandom_range(3))
                    0: begin
                        issue(smec_pkg::OP_PUSH, pick_word());
                        issue(smec_pkg::OP_STORE, $urandom);
                    end
                    1: issue(smec_pkg::OP_RETRIEVE, $urandom);
                    2: issue(smec_pkg::OP_READC, $urandom);
                    default: issue(smec_pkg::OP_READN, $urandom);
                endcase
            end else if (sel < 85) begin
                case ($urandom_range(4))
                    0: issue(smec_pkg::OP_CALL, pick_label());
                    1: issue(smec_pkg::OP_JUMP, pick_label());
                    2: issue(smec_pkg::OP_JZ, pick_label());
                    3: issue(smec_pkg::OP_JNEG, pick_label());
                    default: issue(smec_pkg::OP_RET, $urandom);
                endcase
            end else if (sel < 93) begin
                issue($urandom_range(1) ? smec_pkg::OP_WRITEC : smec_pkg::OP_WRITEN, $urandom);
            end else begin
                case ($urandom_range(2))
                    0: issue(CMD_W'($urandom_range(24, 31)), $urandom);
                    1: issue(smec_pkg::OP_MARK, pick_label());
                    default: issue(CMD_W'($urandom), $urandom, 1'b1);
                endcase
            end
        end

        // Halt, then confirm that nothing acts afterward.
        issue(smec_pkg::OP_PUSH, 32'h0000_0041);
        issue(smec_pkg::OP_WRITEC, 32'd0);
        issue(smec_pkg::OP_END, 32'd0);
        issue(smec_pkg::OP_PUSH, 32'd3);
        issue(5'd27, 32'd0);
        issue(smec_pkg::OP_MARK, 32'd77, 1'b1);
        issue(smec_pkg::OP_RET, 32'd0);
    endtask

    // Idle percentages for the three traffic phases.
    function automatic int send_idle_pct();
        if (sent_cnt < total_instr / 3) return 17;
        if (sent_cnt < 2 * total_instr / 3) return 61;
        return 0;
    endfunction

    function automatic int recv_idle_pct();
        if (sent_cnt < total_instr / 3) return 61;
        if (sent_cnt < 2 * total_instr / 3) return 17;
        return 0;
    endfunction

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Driver: hold each beat until accepted, then advance to the next pending one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_cmd <= '0; s_arg <= '0; s_pc_next <= '0; s_in_value <= '0; s_scan_only <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) sent_cnt <= sent_cnt + 1;
            if (program_q.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
                s_valid     <= 1'b1;
                s_cmd       <= program_q[0].cmd;
                s_arg       <= program_q[0].arg;
                s_pc_next   <= program_q[0].pcn;
                s_in_value  <= program_q[0].inv;
                s_scan_only <= program_q[0].scan;
                program_q.delete(0);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    task automatic log_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
        if (mismatches < 10)
            $display("mismatch %s: expected %h got %h", what, want, got);
        mismatches++;
    endtask

    // Monitor: check each result beat against the oldest owed result.
    always @(posedge aclk) begin
        outcome_t w;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct());
            if (m_valid && m_ready) begin
                if (owed_results.size() == 0) begin
                    log_mismatch("unexpected beat", 32'd0, 32'(m_next_pc));
                end else begin
                    w = owed_results[0];
                    owed_results.delete(0);
                    if (m_next_pc !== w.npc)
                        log_mismatch("next_pc", 32'(w.npc), 32'(m_next_pc));
                    if (m_out_valid !== w.ov)
                        log_mismatch("out_valid", 32'(w.ov), 32'(m_out_valid));
                    if (m_out_is_number !== w.onum)
                        log_mismatch("out_is_number", 32'(w.onum), 32'(m_out_is_number));
                    if (m_out_value !== w.oval) log_mismatch("out_value", w.oval, m_out_value);
                    if (m_halted !== w.halted)
                        log_mismatch("halted", 32'(w.halted), 32'(m_halted));
                    if (m_error !== w.err) log_mismatch("error", 32'(w.err), 32'(m_error));
                end
            end
        end
    end

    initial begin
        sent_cnt = 0;
        mismatches = 0;
        mdl_depth = 0;
        mdl_rdepth = 0;
        mdl_halt = 0;
        for (int i = 0; i < HEAP_DEPTH; i++) mdl_heap[i] = '0;
        for (int i = 0; i < LABEL_COUNT; i++) begin
            mdl_lvld[i] = 0;
            mdl_lkey[i] = '0;
        end
        build_program();
        total_instr = program_q.size();
        aresetn = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        while (program_q.size() != 0 || s_valid !== 1'b0) @(posedge aclk);
        while (owed_results.size() != 0) @(posedge aclk);
        // Drain: let any late beat show up before the verdict.
        repeat (200) @(posedge aclk);
        if (mismatches == 0 && owed_results.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("tb: errors");
        $finish;
    end

endmodule
